// ===== rtl/core/bvh_pkg.sv =====
// constants, codes and types shared by the bucketed vote histogram files
`timescale 1ns / 1ps
`default_nettype none

package bvh_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int COUNT_BITS = 16;

   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int USED_BITS  = $clog2(CAPACITY + 1);
   localparam int SHIFT_BITS = 4;
   localparam int SUM_BITS   = COUNT_BITS + 1;

   localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(4);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   best_key;
      logic [COUNT_BITS-1:0] best_cnt;
      logic [COUNT_BITS-1:0] lead;
      logic [COUNT_BITS-1:0] second;
   } summary_type;

endpackage

`default_nettype wire

// ===== rtl/core/bvh_if.sv =====
// request, response and csr channel interfaces of the bucketed vote histogram
`timescale 1ns / 1ps
`default_nettype none

interface bvh_req_if import bvh_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [KEY_BITS-1:0] key;

   modport source (output valid, cmd, key, input ready);
   modport sink   (input valid, cmd, key, output ready);
endinterface

interface bvh_rsp_if import bvh_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KEY_BITS-1:0]  best_key;
   logic [SUM_BITS-1:0]  top_two_sum;
   logic [USED_BITS-1:0] entries_used;
   logic                 dropped;

   modport source (output valid, best_key, top_two_sum, entries_used, dropped, input ready);
   modport sink   (input valid, best_key, top_two_sum, entries_used, dropped, output ready);
endinterface

interface bvh_csr_if import bvh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SHIFT_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bucketed_vote_histogram.sv =====
// bucketed vote histogram: table scan sequencer, entry memory and result register
//
//   channel  dir  fields                                          handshake
//   req_ch   in   cmd, key                                        valid / ready
//   rsp_ch   out  best_key, top_two_sum, entries_used, dropped    valid / ready
//   csr_ch   in   data (bucket_shift)                             valid / ready, always ready
//
// an add request scans every stored entry through the single compare/update unit on the entry
// memory read port, and the block is not ready for another request until the add or clear is done
// the result is loaded into the output register only once the previous one has been taken
// reset clears the entry count and the result valid and sets the shift to 4; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module bucketed_vote_histogram import bvh_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   bvh_req_if.sink   req_ch,
   bvh_rsp_if.source rsp_ch,
   bvh_csr_if.sink   csr_ch
);

   state_type state_ff, state_in;

   logic [KEY_BITS-1:0]   entry_key_ff   [CAPACITY];
   logic [COUNT_BITS-1:0] entry_count_ff [CAPACITY];
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [COUNT_BITS-1:0] rd_count_ff;

   logic                  mem_we;
   logic [IDX_BITS-1:0]   mem_waddr;
   logic [KEY_BITS-1:0]   mem_wkey;
   logic [COUNT_BITS-1:0] mem_wcount;
   logic [IDX_BITS-1:0]   mem_raddr;

   logic [SHIFT_BITS-1:0] shift_ff;
   logic [USED_BITS-1:0]  used_ff, used_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  clear_ff, clear_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [KEY_BITS-1:0]   bucket_ff, bucket_in;
   logic                  found_ff, found_in;
   summary_type           sum_ff, sum_in;

   logic                  rsp_valid_ff;
   logic [KEY_BITS-1:0]   rsp_best_key_ff;
   logic [SUM_BITS-1:0]   rsp_sum_ff;
   logic [USED_BITS-1:0]  rsp_used_ff;
   logic                  rsp_dropped_ff;

   logic                  req_acc;
   logic                  out_free;
   logic                  load_rsp;
   logic                  match;
   logic                  last_entry;
   logic                  room;
   logic                  do_append;
   logic                  do_drop;
   logic [COUNT_BITS-1:0] upd_count;
   logic [KEY_BITS-1:0]   upd_key;
   summary_type           scan_sum;
   summary_type           final_sum;

   function automatic summary_type fold(input logic [COUNT_BITS-1:0] c,
                                        input logic [KEY_BITS-1:0] k,
                                        input summary_type cur);
      summary_type nxt;
      nxt = cur;
      if (c > cur.best_cnt) begin
         nxt.best_cnt = c;
         nxt.best_key = k;
      end
      if (c > cur.second && c > cur.lead) begin
         nxt.second = cur.lead;
         nxt.lead   = c;
      end else if (c > cur.second) begin
         nxt.second = c;
      end
      return nxt;
   endfunction

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // compare/update unit on the entry just read
   assign match      = (rd_key_ff >> shift_ff) == bucket_ff;
   assign upd_count  = (match && rd_count_ff != COUNT_MAX) ? rd_count_ff + 1'b1 : rd_count_ff;
   assign upd_key    = (match && key_ff < rd_key_ff) ? key_ff : rd_key_ff;
   assign last_entry = (USED_BITS'(idx_ff) + USED_BITS'(1)) == used_ff;
   assign scan_sum   = fold(upd_count, upd_key, sum_ff);

   assign room      = used_ff < USED_BITS'(CAPACITY);
   assign do_append = !clear_ff && !found_ff && room;
   assign do_drop   = !clear_ff && !found_ff && !room;
   assign final_sum = do_append ? fold(COUNT_BITS'(1), key_ff, sum_ff) : sum_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.cmd == CMD_CLEAR || used_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (last_entry) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wkey     = upd_key;
      mem_wcount   = upd_count;
      mem_raddr    = '0;
      load_rsp     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_SCAN: begin
            mem_we    = match;
            mem_raddr = idx_ff + 1'b1;
         end
         ST_FINISH: begin
            load_rsp   = out_free;
            mem_we     = out_free && do_append;
            mem_waddr  = used_ff[IDX_BITS-1:0];
            mem_wkey   = key_ff;
            mem_wcount = COUNT_BITS'(1);
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      used_in   = used_ff;
      idx_in    = idx_ff;
      clear_in  = clear_ff;
      key_in    = key_ff;
      bucket_in = bucket_ff;
      found_in  = found_ff;
      sum_in    = sum_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               clear_in  = req_ch.cmd == CMD_CLEAR;
               key_in    = req_ch.key;
               bucket_in = req_ch.key >> shift_ff;
               found_in  = 1'b0;
               idx_in    = '0;
               sum_in    = '0;
               if (req_ch.cmd == CMD_CLEAR) begin
                  used_in = '0;
               end
            end
         end
         ST_SCAN: begin
            sum_in   = scan_sum;
            found_in = found_ff || match;
            idx_in   = idx_ff + 1'b1;
         end
         ST_FINISH: begin
            if (out_free && do_append) begin
               used_in = used_ff + 1'b1;
            end
         end
         default: begin
            used_in = used_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_key_ff[mem_waddr]   <= mem_wkey;
         entry_count_ff[mem_waddr] <= mem_wcount;
      end
      rd_key_ff   <= entry_key_ff[mem_raddr];
      rd_count_ff <= entry_count_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         shift_ff     <= SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (csr_ch.valid) begin
            shift_ff <= csr_ch.data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      clear_ff  <= clear_in;
      key_ff    <= key_in;
      bucket_ff <= bucket_in;
      found_ff  <= found_in;
      sum_ff    <= sum_in;
      if (load_rsp) begin
         rsp_best_key_ff <= final_sum.best_key;
         rsp_sum_ff      <= SUM_BITS'(final_sum.lead) + SUM_BITS'(final_sum.second);
         rsp_used_ff     <= do_append ? used_ff + 1'b1 : used_ff;
         rsp_dropped_ff  <= do_drop;
      end
   end

   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.best_key     = rsp_best_key_ff;
   assign rsp_ch.top_two_sum  = rsp_sum_ff;
   assign rsp_ch.entries_used = rsp_used_ff;
   assign rsp_ch.dropped      = rsp_dropped_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bvh_checker.sv =====
// port-level assertions for the bucketed vote histogram and their bind
`timescale 1ns / 1ps
`default_nettype none

module bvh_checker import bvh_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [KEY_BITS-1:0]  rsp_best_key,
   input wire logic [SUM_BITS-1:0]  rsp_top_two_sum,
   input wire logic [USED_BITS-1:0] rsp_entries_used,
   input wire logic                 rsp_dropped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted request");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entries_used <= USED_BITS'(CAPACITY))
      else $error("entries_used above capacity");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entries_used == '0 |-> rsp_best_key == '0 && rsp_top_two_sum == '0)
      else $error("empty table with nonzero summary");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> rsp_entries_used == USED_BITS'(CAPACITY))
      else $error("drop reported with room in the table");

endmodule

bind bucketed_vote_histogram bvh_checker u_bvh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_best_key     (rsp_ch.best_key),
   .rsp_top_two_sum  (rsp_ch.top_two_sum),
   .rsp_entries_used (rsp_ch.entries_used),
   .rsp_dropped      (rsp_ch.dropped)
);

`default_nettype wire

// ===== test/bucketed_vote_histogram_tb.sv =====
// testbench for the bucketed vote histogram: random and directed requests against a table model
`timescale 1ns / 1ps

module bucketed_vote_histogram_tb;
   import bvh_pkg::*;

   typedef struct packed {
      logic [KEY_BITS-1:0]  best_key;
      logic [SUM_BITS-1:0]  top_two_sum;
      logic [USED_BITS-1:0] entries_used;
      logic                 dropped;
   } vote_summary_type;

   class vote_tracker;
      logic [KEY_BITS-1:0]   min_key [CAPACITY];
      logic [COUNT_BITS-1:0] votes [CAPACITY];
      logic [USED_BITS-1:0]  used;
      logic [SHIFT_BITS-1:0] shift;
      vote_summary_type      pending_summaries [$];
      int                    mismatches;

      function new();
         used       = '0;
         shift      = SHIFT_RESET;
         mismatches = 0;
      endfunction

      // apply one request to the table and queue the summary it should produce
      function void record_request(logic cmd, logic [KEY_BITS-1:0] key);
         vote_summary_type      s;
         logic [COUNT_BITS-1:0] best_cnt;
         logic [COUNT_BITS-1:0] lead;
         logic [COUNT_BITS-1:0] second;
         bit                    hit;
         int                    i;
         s        = '0;
         hit      = 1'b0;
         best_cnt = '0;
         lead     = '0;
         second   = '0;
         if (cmd == CMD_CLEAR) begin
            used = '0;
         end else begin
            for (i = 0; i < used; i++) begin
               if ((min_key[i] >> shift) == (key >> shift)) begin
                  hit = 1'b1;
                  if (votes[i] != COUNT_MAX)
                     votes[i] = votes[i] + 1'b1;
                  if (key < min_key[i])
                     min_key[i] = key;
               end
            end
            if (!hit) begin
               if (used < CAPACITY) begin
                  min_key[used[IDX_BITS-1:0]] = key;
                  votes[used[IDX_BITS-1:0]]   = COUNT_BITS'(1);
                  used                        = used + 1'b1;
               end else begin
                  s.dropped = 1'b1;
               end
            end
         end
         for (i = 0; i < used; i++) begin
            if (votes[i] > best_cnt) begin
               best_cnt   = votes[i];
               s.best_key = min_key[i];
            end
            if (votes[i] > second && votes[i] > lead) begin
               second = lead;
               lead   = votes[i];
            end else if (votes[i] > second) begin
               second = votes[i];
            end
         end
         s.top_two_sum  = SUM_BITS'(lead) + SUM_BITS'(second);
         s.entries_used = used;
         pending_summaries.push_back(s);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t %s expected %h actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void compare_summary(vote_summary_type got);
         vote_summary_type want;
         if (pending_summaries.size() == 0) begin
            $display("%0t unexpected response expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_summaries.pop_front();
         check_field("best_key", want.best_key, got.best_key);
         check_field("top_two_sum", 32'(want.top_two_sum), 32'(got.top_two_sum));
         check_field("entries_used", 32'(want.entries_used), 32'(got.entries_used));
         check_field("dropped", 32'(want.dropped), 32'(got.dropped));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   idle_on = 1'b1;

   logic [KEY_BITS-1:0] bases [128];
   vote_tracker         tracker = new();

   bvh_req_if req_ch ();
   bvh_rsp_if rsp_ch ();
   bvh_csr_if csr_ch ();

   bucketed_vote_histogram dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   task automatic send_request(logic cmd, logic [KEY_BITS-1:0] key);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.key   <= key;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      tracker.record_request(cmd, key);
   endtask

   task automatic drain_requests();
      req_ch.valid <= 1'b0;
      while (tracker.pending_summaries.size() != 0) @(posedge clock);
   endtask

   task automatic write_shift(logic [SHIFT_BITS-1:0] value);
      drain_requests();
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      tracker.shift = value;
   endtask

   // mostly clusters of keys around random bases so that buckets repeat, plus edge and fully random keys
   function automatic logic [KEY_BITS-1:0] pick_key(int n_bases);
      int r;
      r = $urandom_range(0, 49);
      if (r == 0)
         return '0;
      if (r == 1)
         return '1;
      if (r < 6)
         return $urandom;
      return bases[$urandom_range(0, n_bases - 1)]
         + $urandom_range(0, (1 << (tracker.shift + 1)) - 1);
   endfunction

   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      vote_summary_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.best_key     = rsp_ch.best_key;
         got.top_two_sum  = rsp_ch.top_two_sum;
         got.entries_used = rsp_ch.entries_used;
         got.dropped      = rsp_ch.dropped;
         tracker.compare_summary(got);
      end
   end

   initial begin : stimulus
      int ph;
      int i;
      int n_bases;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd   = CMD_ADD;
      req_ch.key   = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset shift, bucket merge and minimum lowering
      send_request(CMD_ADD, 32'h0000_0000);
      send_request(CMD_ADD, 32'hFFFF_FFFF);
      send_request(CMD_ADD, 32'h0000_000F);
      send_request(CMD_ADD, 32'h0000_0010);
      send_request(CMD_ADD, 32'hFFFF_FFF5);
      send_request(CMD_ADD, 32'hFFFF_FFF0);
      send_request(CMD_CLEAR, 32'hDEAD_BEEF);
      send_request(CMD_CLEAR, 32'h0000_0000);
      send_request(CMD_ADD, 32'h0000_0005);
      write_shift(4'd0);
      send_request(CMD_ADD, 32'h0000_0001);
      send_request(CMD_ADD, 32'h0000_0001);
      send_request(CMD_ADD, 32'h0000_0002);
      send_request(CMD_ADD, 32'h0000_0000);
      // widen the buckets without a clear: several entries match at once
      write_shift(4'd15);
      send_request(CMD_ADD, 32'h0000_7FFF);
      send_request(CMD_ADD, 32'h0000_8000);

      // full table and drops
      send_request(CMD_CLEAR, '0);
      for (i = 0; i < CAPACITY; i++)
         send_request(CMD_ADD, (i << 15) | $urandom_range(0, 32767));
      send_request(CMD_ADD, CAPACITY << 15);
      send_request(CMD_ADD, 32'hFFFF_FFFF);
      send_request(CMD_ADD, (3 << 15) | 5);
      send_request(CMD_CLEAR, '0);

      for (ph = 0; ph < 8; ph++) begin
         idle_on = (ph < 6);
         n_bases = $urandom_range(1, 100);
         for (i = 0; i < n_bases; i++)
            bases[i] = $urandom;
         write_shift(ph == 0 ? 4'd0 : ph == 1 ? 4'd15 : 4'($urandom_range(0, 15)));
         if ($urandom_range(0, 1) == 1)
            send_request(CMD_CLEAR, $urandom);
         for (i = 0; i < 140; i++)
            send_request($urandom_range(0, 39) == 0 ? CMD_CLEAR : CMD_ADD, pick_key(n_bases));
      end

      drain_requests();
      repeat (70) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_summaries.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== bucketed_vote_histogram.f =====
rtl/core/bvh_pkg.sv
rtl/core/bvh_if.sv
rtl/core/bucketed_vote_histogram.sv
rtl/core/bvh_checker.sv
test/bucketed_vote_histogram_tb.sv
